/* sv/glsp_pkg.sv */
// Package for the 3D Lee maze router: command codes, controller states,
// datapath operations, neighbor directions and the controller/datapath structs.
// No dependencies.
`default_nettype none

package glsp_pkg;

   localparam int GRID_SIDE_DEF = 16;
   localparam int COORD_W       = 5;
   localparam int CMD_W         = 2;
   localparam int PATH_CELLS_W  = 13;
   localparam logic [COORD_W-1:0] GSIZE_RESET = 5'd16;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_MARK   = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [4:0] {
      ST_INIT_CLR,
      ST_IDLE,
      ST_DISPATCH,
      ST_CLR,
      ST_MARK,
      ST_SRCH_START,
      ST_DCLR,
      ST_SEED,
      ST_POP,
      ST_POP_WAIT,
      ST_NB_RD,
      ST_NB_CHK,
      ST_TGT_RD,
      ST_TGT_CHK,
      ST_TB_RD,
      ST_TB_CHK,
      ST_PATH_RD,
      ST_PATH_LATCH,
      ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_SWEEP_BLK,
      OP_SWEEP_DIST,
      OP_MARK,
      OP_SEARCH_START,
      OP_SEED,
      OP_POP,
      OP_POP_LATCH,
      OP_NB_RD,
      OP_NB_CHK,
      OP_TGT_RD,
      OP_TGT_CHK,
      OP_TB_RD,
      OP_TB_CHK,
      OP_PATH_LATCH,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      DIR_LVL_DN,
      DIR_ROW_DN,
      DIR_ROW_UP,
      DIR_COL_DN,
      DIR_COL_UP,
      DIR_LVL_UP
   } dir_type;

   // wave order: same-level neighbors, then level below and above
   localparam dir_type WAVE_DIR [6] = '{DIR_ROW_DN, DIR_ROW_UP, DIR_COL_DN,
                                        DIR_COL_UP, DIR_LVL_DN, DIR_LVL_UP};
   // trace-back order: lower level, horizontal, upper level
   localparam dir_type BACK_DIR [6] = '{DIR_LVL_DN, DIR_ROW_DN, DIR_COL_DN,
                                        DIR_COL_UP, DIR_ROW_UP, DIR_LVL_UP};

   typedef struct packed {
      op_type op;
   } ctrl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    sweep_last;
      logic    in_range;
      logic    q_empty;
      logic    nb_inside;
      logic    nb_open;
      logic    k_last;
      logic    tgt_reached;
      logic    tb_done;
      logic    nb_match;
      logic    rd_avail;
      logic    out_free;
   } stat_type;

endpackage

`default_nettype wire

/* sv/glsp_if.sv */
// Channel interfaces of the 3D Lee maze router: command word in, result word out.
// Depends on nothing.
`default_nettype none

interface glsp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [4:0] cell_level;
   logic [4:0] cell_row;
   logic [4:0] cell_col;
   logic [4:0] target_level;
   logic [4:0] target_row;
   logic [4:0] target_col;
   modport source (output valid, command, cell_level, cell_row, cell_col,
                   target_level, target_row, target_col, input ready);
   modport sink (input valid, command, cell_level, cell_row, cell_col,
                 target_level, target_row, target_col, output ready);
endinterface

interface glsp_rsp_if;
   logic        valid;
   logic        ready;
   logic        reachable;
   logic [12:0] path_cells;
   logic [4:0]  out_level;
   logic [4:0]  out_row;
   logic [4:0]  out_col;
   logic        last;
   modport source (output valid, reachable, path_cells, out_level, out_row, out_col,
                   last, input ready);
   modport sink (input valid, reachable, path_cells, out_level, out_row, out_col,
                 last, output ready);
endinterface

`default_nettype wire

/* sv/grid3d_lee_shortest_path.sv */
// Search: one distance-map clearing sweep, then the wave expansion over each queued
// cell and its in-grid neighbors, then the trace-back probes from target to source.
// One command is worked at a time; the next is taken while a result waits.
// After reset the blocked map is swept clear with ready low.
// Top level of the 3D Lee maze router; uses glsp_pkg, glsp_if, glsp_ctrl, glsp_datapath.
`default_nettype none

module grid3d_lee_shortest_path #(
   parameter int GRID_SIDE = glsp_pkg::GRID_SIDE_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   glsp_req_if.sink    req_ch,
   glsp_rsp_if.source  rsp_ch,
   input  wire logic       csr_wr_en,
   input  wire logic [4:0] csr_wr_data
);

   glsp_pkg::ctrl_type ctrl;
   glsp_pkg::stat_type stat;
   logic               req_ready;

   assign req_ch.ready = req_ready;

   // sequence commands
   glsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .ctrl      (ctrl),
      .stat      (stat)
   );

   // hold maps, queue, path and result word
   glsp_datapath #(.GRID_SIDE(GRID_SIDE)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_command      (req_ch.command),
      .req_cell_level   (req_ch.cell_level),
      .req_cell_row     (req_ch.cell_row),
      .req_cell_col     (req_ch.cell_col),
      .req_target_level (req_ch.target_level),
      .req_target_row   (req_ch.target_row),
      .req_target_col   (req_ch.target_col),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_reachable    (rsp_ch.reachable),
      .rsp_path_cells   (rsp_ch.path_cells),
      .rsp_out_level    (rsp_ch.out_level),
      .rsp_out_row      (rsp_ch.out_row),
      .rsp_out_col      (rsp_ch.out_col),
      .rsp_last         (rsp_ch.last)
   );

endmodule

`default_nettype wire

/* sv/glsp_ctrl.sv */
// Controller state machine of the 3D Lee maze router: sequences sweeps, wave
// expansion, trace-back and reads. Depends on glsp_pkg.
`default_nettype none

module glsp_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output glsp_pkg::ctrl_type      ctrl,
   input  wire glsp_pkg::stat_type stat
);

   glsp_pkg::state_type state_ff, state_in;

   // advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= glsp_pkg::ST_INIT_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         glsp_pkg::ST_INIT_CLR: begin
            if (stat.sweep_last) state_in = glsp_pkg::ST_IDLE;
         end
         glsp_pkg::ST_IDLE: begin
            if (req_valid) state_in = glsp_pkg::ST_DISPATCH;
         end
         glsp_pkg::ST_DISPATCH: begin
            case (stat.cmd)
               glsp_pkg::CMD_CLEAR:  state_in = glsp_pkg::ST_CLR;
               glsp_pkg::CMD_MARK:   state_in = glsp_pkg::ST_MARK;
               glsp_pkg::CMD_SEARCH: state_in = glsp_pkg::ST_SRCH_START;
               default: begin
                  state_in = stat.rd_avail ? glsp_pkg::ST_PATH_RD : glsp_pkg::ST_DONE;
               end
            endcase
         end
         glsp_pkg::ST_CLR: begin
            if (stat.sweep_last) state_in = glsp_pkg::ST_DONE;
         end
         glsp_pkg::ST_MARK: state_in = glsp_pkg::ST_DONE;
         glsp_pkg::ST_SRCH_START: begin
            state_in = stat.in_range ? glsp_pkg::ST_DCLR : glsp_pkg::ST_DONE;
         end
         glsp_pkg::ST_DCLR: begin
            if (stat.sweep_last) state_in = glsp_pkg::ST_SEED;
         end
         glsp_pkg::ST_SEED: state_in = glsp_pkg::ST_POP;
         glsp_pkg::ST_POP: begin
            state_in = stat.q_empty ? glsp_pkg::ST_TGT_RD : glsp_pkg::ST_POP_WAIT;
         end
         glsp_pkg::ST_POP_WAIT: state_in = glsp_pkg::ST_NB_RD;
         glsp_pkg::ST_NB_RD: begin
            if (stat.nb_inside) state_in = glsp_pkg::ST_NB_CHK;
            else if (stat.k_last) state_in = glsp_pkg::ST_POP;
         end
         glsp_pkg::ST_NB_CHK: begin
            state_in = stat.k_last ? glsp_pkg::ST_POP : glsp_pkg::ST_NB_RD;
         end
         glsp_pkg::ST_TGT_RD: state_in = glsp_pkg::ST_TGT_CHK;
         glsp_pkg::ST_TGT_CHK: begin
            state_in = stat.tgt_reached ? glsp_pkg::ST_TB_RD : glsp_pkg::ST_DONE;
         end
         glsp_pkg::ST_TB_RD: begin
            if (stat.tb_done) state_in = glsp_pkg::ST_DONE;
            else if (stat.nb_inside) state_in = glsp_pkg::ST_TB_CHK;
            else if (stat.k_last) state_in = glsp_pkg::ST_DONE;
         end
         glsp_pkg::ST_TB_CHK: begin
            if (stat.nb_match) state_in = glsp_pkg::ST_TB_RD;
            else if (stat.k_last) state_in = glsp_pkg::ST_DONE;
            else state_in = glsp_pkg::ST_TB_RD;
         end
         glsp_pkg::ST_PATH_RD: state_in = glsp_pkg::ST_PATH_LATCH;
         glsp_pkg::ST_PATH_LATCH: state_in = glsp_pkg::ST_DONE;
         glsp_pkg::ST_DONE: begin
            if (stat.out_free) state_in = glsp_pkg::ST_IDLE;
         end
         default: state_in = glsp_pkg::ST_IDLE;
      endcase
   end

   // drive datapath operation and handshake
   always_comb begin
      req_ready = 1'b0;
      ctrl.op   = glsp_pkg::OP_NONE;
      case (state_ff)
         glsp_pkg::ST_INIT_CLR: ctrl.op = glsp_pkg::OP_SWEEP_BLK;
         glsp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) ctrl.op = glsp_pkg::OP_LATCH;
         end
         glsp_pkg::ST_CLR:        ctrl.op = glsp_pkg::OP_SWEEP_BLK;
         glsp_pkg::ST_MARK:       ctrl.op = glsp_pkg::OP_MARK;
         glsp_pkg::ST_SRCH_START: ctrl.op = glsp_pkg::OP_SEARCH_START;
         glsp_pkg::ST_DCLR:       ctrl.op = glsp_pkg::OP_SWEEP_DIST;
         glsp_pkg::ST_SEED:       ctrl.op = glsp_pkg::OP_SEED;
         glsp_pkg::ST_POP: begin
            if (!stat.q_empty) ctrl.op = glsp_pkg::OP_POP;
         end
         glsp_pkg::ST_POP_WAIT:   ctrl.op = glsp_pkg::OP_POP_LATCH;
         glsp_pkg::ST_NB_RD:      ctrl.op = glsp_pkg::OP_NB_RD;
         glsp_pkg::ST_NB_CHK:     ctrl.op = glsp_pkg::OP_NB_CHK;
         glsp_pkg::ST_TGT_RD:     ctrl.op = glsp_pkg::OP_TGT_RD;
         glsp_pkg::ST_TGT_CHK:    ctrl.op = glsp_pkg::OP_TGT_CHK;
         glsp_pkg::ST_TB_RD:      ctrl.op = glsp_pkg::OP_TB_RD;
         glsp_pkg::ST_TB_CHK:     ctrl.op = glsp_pkg::OP_TB_CHK;
         glsp_pkg::ST_PATH_LATCH: ctrl.op = glsp_pkg::OP_PATH_LATCH;
         glsp_pkg::ST_DONE: begin
            if (stat.out_free) ctrl.op = glsp_pkg::OP_EMIT;
         end
         default: ctrl.op = glsp_pkg::OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

/* sv/glsp_datapath.sv */
// Datapath of the 3D Lee maze router: blocked, distance, wave queue and path
// memories, neighbor generation, counters and the result register. Depends on glsp_pkg.
`default_nettype none

module glsp_datapath #(
   parameter int GRID_SIDE = glsp_pkg::GRID_SIDE_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire glsp_pkg::ctrl_type ctrl,
   output glsp_pkg::stat_type      stat,
   input  wire logic [1:0]         req_command,
   input  wire logic [4:0]         req_cell_level,
   input  wire logic [4:0]         req_cell_row,
   input  wire logic [4:0]         req_cell_col,
   input  wire logic [4:0]         req_target_level,
   input  wire logic [4:0]         req_target_row,
   input  wire logic [4:0]         req_target_col,
   input  wire logic               csr_wr_en,
   input  wire logic [4:0]         csr_wr_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_reachable,
   output logic [12:0]             rsp_path_cells,
   output logic [4:0]              rsp_out_level,
   output logic [4:0]              rsp_out_row,
   output logic [4:0]              rsp_out_col,
   output logic                    rsp_last
);

   localparam int CW    = $clog2(GRID_SIDE);
   localparam int IW    = 3 * CW;
   localparam int DEPTH = 1 << IW;
   localparam int DW    = IW + 1;
   localparam int SW    = CW + 1;
   localparam int CRW   = ((SW > 5) ? SW : 5) + 1;
   localparam int QW    = IW + DW;

   // memories
   logic          blk_mem  [DEPTH];
   logic [DW-1:0] dist_mem [DEPTH];
   logic [QW-1:0] q_mem    [DEPTH];
   logic [IW-1:0] path_mem [DEPTH];

   logic          blk_rd_ff;
   logic [DW-1:0] dist_rd_ff;
   logic [QW-1:0] q_rd_ff;
   logic [IW-1:0] path_rd_ff;

   // control registers
   logic [4:0]    gsize_ff;
   logic [IW-1:0] sweep_ff;
   logic [IW:0]   head_ff;
   logic [IW:0]   tail_ff;
   logic [2:0]    k_ff;
   logic [DW-1:0] len_ff;
   logic [DW-1:0] rp_ff;
   logic          reach_ff;
   logic          rsp_valid_ff;

   // payload registers
   glsp_pkg::cmd_type cmd_ff;
   logic [4:0]    cl_ff, cr_ff, cc_ff, tl_ff, tr_ff, tc_ff;
   logic [IW-1:0] cur_ff;
   logic [DW-1:0] cd_ff;
   logic [DW-1:0] pos_ff;
   logic [4:0]    ol_ff, or_ff, oc_ff;
   logic          olast_ff;
   logic          rsp_reach_ff;
   logic [12:0]   rsp_len_ff;
   logic [4:0]    rsp_l_ff, rsp_r_ff, rsp_c_ff;
   logic          rsp_last_ff;

   glsp_pkg::op_type op;
   assign op = ctrl.op;

   function automatic logic in_cube(logic [CRW-1:0] l, logic [CRW-1:0] r,
                                    logic [CRW-1:0] c, logic [SW-1:0] n);
      logic [CRW-1:0] nn;
      nn = CRW'(n);
      return (l != '0) && (l <= nn) && (r != '0) && (r <= nn) &&
             (c != '0) && (c <= nn);
   endfunction

   function automatic logic [IW-1:0] to_idx(logic [CRW-1:0] l, logic [CRW-1:0] r,
                                            logic [CRW-1:0] c);
      logic [CRW-1:0] lm, rm, cm;
      lm = l - CRW'(1);
      rm = r - CRW'(1);
      cm = c - CRW'(1);
      return {lm[CW-1:0], rm[CW-1:0], cm[CW-1:0]};
   endfunction

   // clamp grid size into 1..GRID_SIDE
   logic [SW-1:0] side;
   always_comb begin
      if (gsize_ff == 5'd0) side = SW'(1);
      else if (int'(gsize_ff) > GRID_SIDE) side = SW'(GRID_SIDE);
      else side = SW'(gsize_ff);
   end

   // source and target cells
   logic          src_in, tgt_in;
   logic [IW-1:0] src_idx, tgt_idx;
   assign src_in  = in_cube(CRW'(cl_ff), CRW'(cr_ff), CRW'(cc_ff), side);
   assign tgt_in  = in_cube(CRW'(tl_ff), CRW'(tr_ff), CRW'(tc_ff), side);
   assign src_idx = to_idx(CRW'(cl_ff), CRW'(cr_ff), CRW'(cc_ff));
   assign tgt_idx = to_idx(CRW'(tl_ff), CRW'(tr_ff), CRW'(tc_ff));

   // neighbor of the current cell in the selected direction
   logic [CRW-1:0]    cur_l, cur_r, cur_c, nb_l, nb_r, nb_c;
   glsp_pkg::dir_type dir;
   logic              nb_inside;
   logic [IW-1:0]     nb_idx;
   logic              tb_phase;

   assign tb_phase = (op == glsp_pkg::OP_TB_RD) || (op == glsp_pkg::OP_TB_CHK);
   assign cur_l = CRW'(cur_ff[IW-1:2*CW]) + CRW'(1);
   assign cur_r = CRW'(cur_ff[2*CW-1:CW]) + CRW'(1);
   assign cur_c = CRW'(cur_ff[CW-1:0]) + CRW'(1);

   always_comb begin
      dir  = tb_phase ? glsp_pkg::BACK_DIR[k_ff] : glsp_pkg::WAVE_DIR[k_ff];
      nb_l = cur_l;
      nb_r = cur_r;
      nb_c = cur_c;
      case (dir)
         glsp_pkg::DIR_LVL_DN: nb_l = cur_l - CRW'(1);
         glsp_pkg::DIR_LVL_UP: nb_l = cur_l + CRW'(1);
         glsp_pkg::DIR_ROW_DN: nb_r = cur_r - CRW'(1);
         glsp_pkg::DIR_ROW_UP: nb_r = cur_r + CRW'(1);
         glsp_pkg::DIR_COL_DN: nb_c = cur_c - CRW'(1);
         glsp_pkg::DIR_COL_UP: nb_c = cur_c + CRW'(1);
         default: nb_l = cur_l;
      endcase
   end

   assign nb_inside = in_cube(nb_l, nb_r, nb_c, side);
   assign nb_idx    = to_idx(nb_l, nb_r, nb_c);

   // status decode
   logic nb_open, nb_match, tb_done, k_last, out_free, tgt_reached;
   assign nb_open     = !blk_rd_ff && (dist_rd_ff == '0);
   assign nb_match    = dist_rd_ff == (cd_ff - DW'(1));
   assign tb_done     = (pos_ff == '0) || (cd_ff < DW'(2));
   assign k_last      = k_ff == 3'd5;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign tgt_reached = dist_rd_ff != '0;

   always_comb begin
      stat.cmd         = cmd_ff;
      stat.sweep_last  = &sweep_ff;
      stat.in_range    = src_in && tgt_in;
      stat.q_empty     = head_ff == tail_ff;
      stat.nb_inside   = nb_inside;
      stat.nb_open     = nb_open;
      stat.k_last      = k_last;
      stat.tgt_reached = tgt_reached;
      stat.tb_done     = tb_done;
      stat.nb_match    = nb_match;
      stat.rd_avail    = rp_ff < len_ff;
      stat.out_free    = out_free;
   end

   // blocked map port
   logic          blk_we, blk_wd;
   logic [IW-1:0] blk_wa;
   always_comb begin
      blk_we = 1'b0;
      blk_wd = 1'b0;
      blk_wa = sweep_ff;
      if (op == glsp_pkg::OP_SWEEP_BLK) begin
         blk_we = 1'b1;
      end else if (op == glsp_pkg::OP_MARK && src_in) begin
         blk_we = 1'b1;
         blk_wd = 1'b1;
         blk_wa = src_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (blk_we) blk_mem[blk_wa] <= blk_wd;
      blk_rd_ff <= blk_mem[nb_idx];
   end

   // distance map port
   logic          dist_we;
   logic [IW-1:0] dist_wa, dist_ra;
   logic [DW-1:0] dist_wd;
   always_comb begin
      dist_we = 1'b0;
      dist_wa = sweep_ff;
      dist_wd = '0;
      if (op == glsp_pkg::OP_SWEEP_DIST) begin
         dist_we = 1'b1;
      end else if (op == glsp_pkg::OP_SEED) begin
         dist_we = 1'b1;
         dist_wa = src_idx;
         dist_wd = DW'(1);
      end else if (op == glsp_pkg::OP_NB_CHK && nb_open) begin
         dist_we = 1'b1;
         dist_wa = nb_idx;
         dist_wd = cd_ff + DW'(1);
      end
   end
   assign dist_ra = (op == glsp_pkg::OP_TGT_RD) ? tgt_idx : nb_idx;

   always_ff @(posedge clock) begin
      if (dist_we) dist_mem[dist_wa] <= dist_wd;
      dist_rd_ff <= dist_mem[dist_ra];
   end

   // wave queue port
   logic          q_we;
   logic [IW-1:0] q_wa;
   logic [QW-1:0] q_wd;
   always_comb begin
      q_we = 1'b0;
      q_wa = tail_ff[IW-1:0];
      q_wd = {nb_idx, cd_ff + DW'(1)};
      if (op == glsp_pkg::OP_SEED) begin
         q_we = 1'b1;
         q_wa = '0;
         q_wd = {src_idx, DW'(1)};
      end else if (op == glsp_pkg::OP_NB_CHK && nb_open) begin
         q_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_we) q_mem[q_wa] <= q_wd;
      q_rd_ff <= q_mem[head_ff[IW-1:0]];
   end

   // path store port
   logic          path_we;
   logic [IW-1:0] path_wa, path_wd;
   logic [DW-1:0] tgt_pos, prev_pos;
   assign tgt_pos  = dist_rd_ff - DW'(1);
   assign prev_pos = pos_ff - DW'(1);
   always_comb begin
      path_we = 1'b0;
      path_wa = tgt_pos[IW-1:0];
      path_wd = tgt_idx;
      if (op == glsp_pkg::OP_TGT_CHK && tgt_reached) begin
         path_we = 1'b1;
      end else if (op == glsp_pkg::OP_TB_CHK && nb_match) begin
         path_we = 1'b1;
         path_wa = prev_pos[IW-1:0];
         path_wd = nb_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (path_we) path_mem[path_wa] <= path_wd;
      path_rd_ff <= path_mem[rp_ff[IW-1:0]];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gsize_ff     <= glsp_pkg::GSIZE_RESET;
         sweep_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         k_ff         <= '0;
         len_ff       <= '0;
         rp_ff        <= '0;
         reach_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) gsize_ff <= csr_wr_data;
         case (op)
            glsp_pkg::OP_SWEEP_BLK, glsp_pkg::OP_SWEEP_DIST: sweep_ff <= sweep_ff + 1'b1;
            glsp_pkg::OP_SEARCH_START: begin
               reach_ff <= 1'b0;
               len_ff   <= '0;
               rp_ff    <= '0;
            end
            glsp_pkg::OP_SEED: begin
               head_ff <= '0;
               tail_ff <= (IW+1)'(1);
            end
            glsp_pkg::OP_POP:       head_ff <= head_ff + 1'b1;
            glsp_pkg::OP_POP_LATCH: k_ff <= '0;
            glsp_pkg::OP_NB_RD: begin
               if (!nb_inside && !k_last) k_ff <= k_ff + 3'd1;
            end
            glsp_pkg::OP_NB_CHK: begin
               if (nb_open) tail_ff <= tail_ff + 1'b1;
               if (!k_last) k_ff <= k_ff + 3'd1;
            end
            glsp_pkg::OP_TGT_CHK: begin
               if (tgt_reached) begin
                  reach_ff <= 1'b1;
                  len_ff   <= dist_rd_ff;
                  k_ff     <= '0;
               end
            end
            glsp_pkg::OP_TB_RD: begin
               if (!tb_done && !nb_inside && !k_last) k_ff <= k_ff + 3'd1;
            end
            glsp_pkg::OP_TB_CHK: begin
               if (nb_match) k_ff <= '0;
               else if (!k_last) k_ff <= k_ff + 3'd1;
            end
            glsp_pkg::OP_PATH_LATCH: rp_ff <= rp_ff + 1'b1;
            default: ;
         endcase
         if (op == glsp_pkg::OP_EMIT) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (op)
         glsp_pkg::OP_LATCH: begin
            cmd_ff   <= glsp_pkg::cmd_type'(req_command);
            cl_ff    <= req_cell_level;
            cr_ff    <= req_cell_row;
            cc_ff    <= req_cell_col;
            tl_ff    <= req_target_level;
            tr_ff    <= req_target_row;
            tc_ff    <= req_target_col;
            ol_ff    <= '0;
            or_ff    <= '0;
            oc_ff    <= '0;
            olast_ff <= 1'b0;
         end
         glsp_pkg::OP_POP_LATCH: begin
            cur_ff <= q_rd_ff[QW-1:DW];
            cd_ff  <= q_rd_ff[DW-1:0];
         end
         glsp_pkg::OP_TGT_CHK: begin
            cur_ff <= tgt_idx;
            cd_ff  <= dist_rd_ff;
            pos_ff <= tgt_pos;
         end
         glsp_pkg::OP_TB_CHK: begin
            if (nb_match) begin
               cur_ff <= nb_idx;
               cd_ff  <= cd_ff - DW'(1);
               pos_ff <= prev_pos;
            end
         end
         glsp_pkg::OP_PATH_LATCH: begin
            ol_ff    <= 5'(CRW'(path_rd_ff[IW-1:2*CW]) + CRW'(1));
            or_ff    <= 5'(CRW'(path_rd_ff[2*CW-1:CW]) + CRW'(1));
            oc_ff    <= 5'(CRW'(path_rd_ff[CW-1:0]) + CRW'(1));
            olast_ff <= (rp_ff + DW'(1)) == len_ff;
         end
         glsp_pkg::OP_EMIT: begin
            rsp_reach_ff <= reach_ff;
            rsp_len_ff   <= 13'(len_ff);
            rsp_l_ff     <= ol_ff;
            rsp_r_ff     <= or_ff;
            rsp_c_ff     <= oc_ff;
            rsp_last_ff  <= olast_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reachable  = rsp_reach_ff;
   assign rsp_path_cells = rsp_len_ff;
   assign rsp_out_level  = rsp_l_ff;
   assign rsp_out_row    = rsp_r_ff;
   assign rsp_out_col    = rsp_c_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

/* sv/glsp_checker.sv */
// Port-level checks on the result word of the 3D Lee maze router, bound to the
// top level. Depends on grid3d_lee_shortest_path and glsp_if.
`default_nettype none

module glsp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_reachable,
   input wire logic [12:0] rsp_path_cells,
   input wire logic [4:0]  rsp_out_level,
   input wire logic [4:0]  rsp_out_row,
   input wire logic [4:0]  rsp_out_col,
   input wire logic        rsp_last
);

   // hold a stalled word
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_reachable, rsp_path_cells, rsp_out_level,
                                          rsp_out_row, rsp_out_col, rsp_last}))
      else $error("result word changed while stalled");

   // a path end only exists after a successful search
   a_last_reach: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_reachable)
      else $error("last flag without a reachable path");

   a_cell_reach: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_level != 5'd0 || rsp_out_row != 5'd0 || rsp_out_col != 5'd0)
      |-> rsp_reachable)
      else $error("path cell given without a reachable path");

   a_unreach_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reachable |-> rsp_path_cells == 13'd0)
      else $error("path length nonzero for unreachable target");

endmodule

bind grid3d_lee_shortest_path glsp_checker u_glsp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_reachable  (rsp_ch.reachable),
   .rsp_path_cells (rsp_ch.path_cells),
   .rsp_out_level  (rsp_ch.out_level),
   .rsp_out_row    (rsp_ch.out_row),
   .rsp_out_col    (rsp_ch.out_col),
   .rsp_last       (rsp_ch.last)
);

`default_nettype wire

/* tb/sv/grid3d_lee_shortest_path_tb.sv */
// Self-checking testbench for the 3D Lee maze router: directed table, then random
// mark/search/read sequences over several grid sizes, with random gaps on both sides.
// Depends on glsp_pkg, glsp_if and grid3d_lee_shortest_path.
`default_nettype none

module grid3d_lee_shortest_path_tb;

   localparam int SIDE      = 16;
   localparam int CELLS     = SIDE * SIDE * SIDE;
   localparam int MAX_GAP   = 17;
   localparam longint LIMIT = 20_000_000;

   typedef struct {
      logic        reachable;
      logic [12:0] path_cells;
      logic [4:0]  lvl;
      logic [4:0]  row;
      logic [4:0]  col;
      logic        last;
   } route_rsp_type;

   typedef struct {
      glsp_pkg::cmd_type cmd;
      logic [4:0]        cl, cr, cc, tl, tr, tc;
      bit                typed;
      route_rsp_type     want;
   } dir_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [4:0] csr_wr_data;

   glsp_req_if req_ch ();
   glsp_rsp_if rsp_ch ();

   grid3d_lee_shortest_path dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // router mirror state
   bit          blk_map [CELLS];
   logic [12:0] dist_map [CELLS];
   logic [11:0] wave_q [CELLS];
   logic [11:0] route_cells [CELLS];
   int          route_len;
   int          read_ptr;
   bit          reach_flag;
   logic [4:0]  grid_cfg;
   int          wave_tail;
   int          back_cell;

   route_rsp_type pending_rsp [$];
   int            errors;
   longint        cycles;
   dir_row_type   dir_rows [$];

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // cut the run off at the cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int side_now();
      if (grid_cfg == 5'd0) return 1;
      if (grid_cfg > SIDE) return SIDE;
      return int'(grid_cfg);
   endfunction

   function automatic bit in_cube(int l, int r, int c, int n);
      return l >= 1 && l <= n && r >= 1 && r <= n && c >= 1 && c <= n;
   endfunction

   function automatic int cell_idx(int l, int r, int c);
      return ((l - 1) * SIDE + (r - 1)) * SIDE + (c - 1);
   endfunction

   function automatic void wave_visit(int l, int r, int c, int n, int d);
      int k;
      if (!in_cube(l, r, c, n)) return;
      k = cell_idx(l, r, c);
      if (blk_map[k] || dist_map[k] != 0) return;
      if (wave_tail >= CELLS) return;
      dist_map[k] = 13'(d + 1);
      wave_q[wave_tail] = 12'(k);
      wave_tail++;
   endfunction

   function automatic bit back_probe(int l, int r, int c, int n, int want);
      int k;
      if (!in_cube(l, r, c, n)) return 0;
      k = cell_idx(l, r, c);
      if (dist_map[k] != want) return 0;
      back_cell = k;
      return 1;
   endfunction

   // run the wave and trace the target back to the source
   function automatic void route_search(int sl, int sr, int sc, int tl, int tr, int tc);
      int n, head, here, d, l, r, c, src, tgt, cur, pos, cd;
      bit found;
      n = side_now();
      reach_flag = 0;
      route_len = 0;
      read_ptr = 0;
      if (!in_cube(sl, sr, sc, n) || !in_cube(tl, tr, tc, n)) return;
      foreach (dist_map[i]) dist_map[i] = '0;
      src = cell_idx(sl, sr, sc);
      tgt = cell_idx(tl, tr, tc);
      dist_map[src] = 13'd1;
      wave_q[0] = 12'(src);
      wave_tail = 1;
      head = 0;
      while (head < wave_tail) begin
         here = wave_q[head];
         head++;
         d = dist_map[here];
         c = here % SIDE + 1;
         r = (here / SIDE) % SIDE + 1;
         l = here / (SIDE * SIDE) + 1;
         wave_visit(l, r - 1, c, n, d);
         wave_visit(l, r + 1, c, n, d);
         wave_visit(l, r, c - 1, n, d);
         wave_visit(l, r, c + 1, n, d);
         wave_visit(l - 1, r, c, n, d);
         wave_visit(l + 1, r, c, n, d);
      end
      if (dist_map[tgt] == 0) return;
      reach_flag = 1;
      route_len = dist_map[tgt];
      cur = tgt;
      pos = route_len - 1;
      route_cells[pos] = 12'(cur);
      while (pos > 0) begin
         c = cur % SIDE + 1;
         r = (cur / SIDE) % SIDE + 1;
         l = cur / (SIDE * SIDE) + 1;
         cd = dist_map[cur];
         if (cd < 2) break;
         found = back_probe(l - 1, r, c, n, cd - 1);
         if (!found) found = back_probe(l, r - 1, c, n, cd - 1);
         if (!found) found = back_probe(l, r, c - 1, n, cd - 1);
         if (!found) found = back_probe(l, r, c + 1, n, cd - 1);
         if (!found) found = back_probe(l, r + 1, c, n, cd - 1);
         if (!found) found = back_probe(l + 1, r, c, n, cd - 1);
         if (!found) break;
         cur = back_cell;
         pos--;
         route_cells[pos] = 12'(cur);
      end
   endfunction

   function automatic route_rsp_type route_predict(glsp_pkg::cmd_type cmd, logic [4:0] cl,
                                                   logic [4:0] cr, logic [4:0] cc,
                                                   logic [4:0] tl, logic [4:0] tr,
                                                   logic [4:0] tc);
      route_rsp_type p;
      int k;
      p = '{0, 0, 0, 0, 0, 0};
      case (cmd)
         glsp_pkg::CMD_CLEAR: begin
            foreach (blk_map[i]) blk_map[i] = 0;
         end
         glsp_pkg::CMD_MARK: begin
            if (in_cube(cl, cr, cc, side_now())) blk_map[cell_idx(cl, cr, cc)] = 1;
         end
         glsp_pkg::CMD_SEARCH: begin
            route_search(cl, cr, cc, tl, tr, tc);
         end
         default: begin
            if (read_ptr < route_len) begin
               k = route_cells[read_ptr];
               p.col = 5'(k % SIDE + 1);
               p.row = 5'((k / SIDE) % SIDE + 1);
               p.lvl = 5'(k / (SIDE * SIDE) + 1);
               p.last = (read_ptr + 1 == route_len);
               read_ptr++;
            end
         end
      endcase
      p.reachable = reach_flag;
      p.path_cells = 13'(route_len);
      return p;
   endfunction

   // present one command word and hold it until taken
   task automatic send_word(glsp_pkg::cmd_type cmd, logic [4:0] cl, logic [4:0] cr,
                            logic [4:0] cc, logic [4:0] tl, logic [4:0] tr,
                            logic [4:0] tc, bit typed, route_rsp_type want);
      int gap;
      route_rsp_type p;
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.command      <= cmd;
      req_ch.cell_level   <= cl;
      req_ch.cell_row     <= cr;
      req_ch.cell_col     <= cc;
      req_ch.target_level <= tl;
      req_ch.target_row   <= tr;
      req_ch.target_col   <= tc;
      do @(posedge clock); while (!req_ch.ready);
      p = route_predict(cmd, cl, cr, cc, tl, tr, tc);
      pending_rsp.push_back(typed ? want : p);
   endtask

   task automatic send_plain(glsp_pkg::cmd_type cmd, logic [4:0] cl, logic [4:0] cr,
                             logic [4:0] cc, logic [4:0] tl, logic [4:0] tr,
                             logic [4:0] tc);
      route_rsp_type none;
      none = '{0, 0, 0, 0, 0, 0};
      send_word(cmd, cl, cr, cc, tl, tr, tc, 0, none);
   endtask

   // drain, then write the grid size while the block is idle
   task automatic set_grid(logic [4:0] v);
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      grid_cfg = v;
      @(posedge clock);
   endtask

   function automatic logic [4:0] pick_coord(int n, int raw_odds);
      if ($urandom_range(0, raw_odds) == 0) return 5'($urandom);
      return 5'($urandom_range(1, n));
   endfunction

   // take result words with random stalls and check them
   initial begin
      int stall;
      route_rsp_type e;
      rsp_ch.ready <= 1'b0;
      forever begin
         stall = $urandom_range(0, MAX_GAP);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (pending_rsp.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_ch.reachable !== e.reachable) begin
               $error("reachable: expected %0d, got %0d", e.reachable, rsp_ch.reachable);
               errors++;
            end
            if (rsp_ch.path_cells !== e.path_cells) begin
               $error("path_cells: expected %0d, got %0d", e.path_cells, rsp_ch.path_cells);
               errors++;
            end
            if (rsp_ch.out_level !== e.lvl) begin
               $error("out_level: expected %0d, got %0d", e.lvl, rsp_ch.out_level);
               errors++;
            end
            if (rsp_ch.out_row !== e.row) begin
               $error("out_row: expected %0d, got %0d", e.row, rsp_ch.out_row);
               errors++;
            end
            if (rsp_ch.out_col !== e.col) begin
               $error("out_col: expected %0d, got %0d", e.col, rsp_ch.out_col);
               errors++;
            end
            if (rsp_ch.last !== e.last) begin
               $error("last: expected %0d, got %0d", e.last, rsp_ch.last);
               errors++;
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [4:0] sizes [12];
      logic [4:0] sl, sr, sc, tl, tr, tc;
      int n, seqs, marks, reads;
      errors = 0;
      cycles = 0;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= glsp_pkg::GSIZE_RESET;
      req_ch.valid <= 1'b0;
      req_ch.command <= glsp_pkg::CMD_CLEAR;
      req_ch.cell_level <= '0;
      req_ch.cell_row <= '0;
      req_ch.cell_col <= '0;
      req_ch.target_level <= '0;
      req_ch.target_row <= '0;
      req_ch.target_col <= '0;
      foreach (blk_map[i]) blk_map[i] = 0;
      foreach (dist_map[i]) dist_map[i] = '0;
      route_len = 0;
      read_ptr = 0;
      reach_flag = 0;
      grid_cfg = glsp_pkg::GSIZE_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed rows at the reset grid size
      dir_rows.push_back('{glsp_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_SEARCH, 0, 1, 1, 1, 1, 1, 1, '{0, 0, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_SEARCH, 1, 1, 1, 1, 1, 1, 1, '{1, 1, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 1, '{1, 1, 1, 1, 1, 1}});
      dir_rows.push_back('{glsp_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 1, '{1, 1, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_SEARCH, 16, 16, 16, 16, 16, 16, 1,
                           '{1, 1, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 1, '{1, 1, 16, 16, 16, 1}});
      dir_rows.push_back('{glsp_pkg::CMD_MARK, 31, 31, 31, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_MARK, 2, 1, 1, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 1, '{1, 1, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_SEARCH, 1, 1, 1, 2, 1, 1, 1, '{0, 0, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_MARK, 1, 1, 1, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_MARK, 1, 1, 2, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_SEARCH, 1, 1, 1, 1, 1, 3, 0, '{0, 0, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_SEARCH, 16, 16, 16, 1, 1, 1, 0,
                           '{0, 0, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_SEARCH, 1, 1, 1, 17, 16, 16, 1,
                           '{0, 0, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_SEARCH, 1, 1, 1, 1, 1, 2, 1, '{1, 2, 0, 0, 0, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 1, '{1, 2, 1, 1, 1, 0}});
      dir_rows.push_back('{glsp_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 1, '{1, 2, 1, 1, 2, 1}});
      foreach (dir_rows[i])
         send_word(dir_rows[i].cmd, dir_rows[i].cl, dir_rows[i].cr, dir_rows[i].cc,
                   dir_rows[i].tl, dir_rows[i].tr, dir_rows[i].tc,
                   dir_rows[i].typed, dir_rows[i].want);

      // random phases over grid sizes, extremes and out-of-range values included
      sizes = '{5'd1, 5'd2, 5'd3, 5'd0, 5'd4, 5'd31, 5'd5, 5'd6, 5'd16, 5'd3, 5'd8, 5'd2};
      foreach (sizes[p]) begin
         set_grid(sizes[p]);
         n = side_now();
         seqs = (n >= 8) ? 4 : 14;
         repeat (seqs) begin
            if ($urandom_range(0, 7) == 0)
               send_plain(glsp_pkg::CMD_CLEAR, 5'($urandom), 5'($urandom), 5'($urandom),
                          5'($urandom), 5'($urandom), 5'($urandom));
            marks = $urandom_range(0, (n == 1) ? 1 : 8);
            repeat (marks)
               send_plain(glsp_pkg::CMD_MARK, pick_coord(n, 7), pick_coord(n, 7),
                          pick_coord(n, 7), 5'($urandom), 5'($urandom), 5'($urandom));
            sl = pick_coord(n, 30);
            sr = pick_coord(n, 30);
            sc = pick_coord(n, 30);
            tl = pick_coord(n, 30);
            tr = pick_coord(n, 30);
            tc = pick_coord(n, 30);
            send_plain(glsp_pkg::CMD_SEARCH, sl, sr, sc, tl, tr, tc);
            reads = route_len + $urandom_range(0, 2);
            repeat (reads)
               send_plain(glsp_pkg::CMD_READ, 5'($urandom), 5'($urandom), 5'($urandom),
                          5'($urandom), 5'($urandom), 5'($urandom));
            // drop in a raw word now and then
            if ($urandom_range(0, 3) == 0)
               send_plain(glsp_pkg::cmd_type'($urandom_range(0, 3)), 5'($urandom),
                          5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                          5'($urandom));
         end
      end

      // drain and let the block settle
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* grid3d_lee_shortest_path.f */
sv/glsp_pkg.sv
sv/glsp_if.sv
sv/glsp_ctrl.sv
sv/glsp_datapath.sv
sv/grid3d_lee_shortest_path.sv
sv/glsp_checker.sv
tb/sv/grid3d_lee_shortest_path_tb.sv
